>>> rtl/matrix_multiply_accumulate_unit_assert.svh
// Assertion macros used by the matrix multiply-accumulate RTL.
// Expect signals named clk and rst in the module that uses them.
`ifndef MATRIX_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mma_pkg.sv
// Shared types and codes for the matrix multiply-accumulate unit.
// No dependencies.
package mma_pkg;

  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_LOAD_C  = 2'd2;
  localparam logic [1:0] MODE_COMPUTE = 2'd3;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [3:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] operand;
    logic signed [47:0] acc_init;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [47:0] out_value;
    logic               out_last;
  } res_item_t;

endpackage

>>> rtl/matrix_multiply_accumulate_unit.sv
// Matrix multiply-accumulate unit, C += A*B, Q8.8 operands, saturating Q32.16 sums.
// Load items retire at one per cycle while the back end is idle; a compute item holds the
// back end through every multiply-accumulate over the effective rows_a, cols_b and inner_dim,
// one per cycle unless a result waits on res_ready, until its pipeline drains. Synchronous
// active-high rst: registers back to 8, queue and pipeline empty, C reads as zero. A and B
// hold garbage until loaded. Uses mma_pkg.
module matrix_multiply_accumulate_unit #(
  parameter int MAX_DIM      = 8,
  parameter int OPERAND_BITS = 16,
  parameter int ACC_BITS     = 48,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mma_pkg::cmd_item_t cmd,
  // result channel
  output logic               res_valid,
  input  logic               res_ready,
  output mma_pkg::res_item_t res,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mma_pkg::*;

  logic [3:0] rows_a;
  logic [3:0] inner_dim;
  logic [3:0] cols_b;
  logic       cfg_wr;

  logic       q_full;
  logic       q_push;
  logic       q_valid;
  logic       q_pop;
  cmd_item_t  front_job;
  cmd_item_t  q_job;

  // --- register port: zero wait states, write on the access phase ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS_A:    rows_a    <= pwdata[3:0];
        REG_INNER_DIM: inner_dim <= pwdata[3:0];
        REG_COLS_B:    cols_b    <= pwdata[3:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:    prdata = {28'd0, rows_a};
      REG_INNER_DIM: prdata = {28'd0, inner_dim};
      REG_COLS_B:    prdata = {28'd0, cols_b};
      default:       prdata = 32'd0;
    endcase
  end

  // --- front end: accept and screen items ---
  mma_front #(.MAX_DIM(MAX_DIM)) u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (q_push),
    .job       (front_job)
  );

  // --- decoupling queue: front keeps taking items while a compute runs, until it is full ---
  mma_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_job)
  );

  // --- back end: stores, MAC pipeline and result register ---
  mma_back #(
    .MAX_DIM      (MAX_DIM),
    .OPERAND_BITS (OPERAND_BITS),
    .ACC_BITS     (ACC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rows_a    (rows_a),
    .inner_dim (inner_dim),
    .cols_b    (cols_b),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

>>> rtl/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mma_front.sv
// Front end: takes items and drops loads that fall outside the stores.
// Depends on mma_pkg.
module mma_front #(
  parameter int MAX_DIM = 8
) (
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mma_pkg::cmd_item_t cmd,
  input  logic              q_full,
  output logic              push,
  output mma_pkg::cmd_item_t job
);
  import mma_pkg::*;

  logic keep;

  // loads with an index past the store edge are accepted and discarded
  assign keep = (cmd.mode == MODE_COMPUTE) ||
                ((4'(cmd.row_index) < 4'(MAX_DIM)) && (4'(cmd.col_index) < 4'(MAX_DIM)));

  assign cmd_ready = !q_full;
  assign push      = cmd_valid && !q_full && keep;
  assign job       = cmd;

endmodule

>>> rtl/mma_queue.sv
// Small FIFO of items between the front end and the execution engine.
// Depends on mma_pkg.
module mma_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mma_pkg::cmd_item_t din,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output mma_pkg::cmd_item_t dout
);
  import mma_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mma_back.sv
// Execution engine: store writes and the multiply-accumulate sequencer.
// Depends on mma_pkg, mma_ram and the assertion macro header.
`include "matrix_multiply_accumulate_unit_assert.svh"

module mma_back #(
  parameter int MAX_DIM      = 8,
  parameter int OPERAND_BITS = 16,
  parameter int ACC_BITS     = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         rows_a,
  input  logic [3:0]         inner_dim,
  input  logic [3:0]         cols_b,
  input  logic               job_valid,
  input  mma_pkg::cmd_item_t job,
  output logic               job_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output mma_pkg::res_item_t res
);
  import mma_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = 2 * OPERAND_BITS;
  localparam int SUM_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;

  localparam logic signed [63:0] OP_HI = $signed(64'({1'b0, {63{1'b1}}} >> (64 - OPERAND_BITS)));
  localparam logic signed [63:0] OP_LO = ~OP_HI;
  localparam logic signed [63:0] INIT_HI = $signed(64'({1'b0, {63{1'b1}}} >> (64 - ACC_BITS)));
  localparam logic signed [63:0] INIT_LO = ~INIT_HI;
  localparam logic signed [SUM_W-1:0] S_HI =
    $signed(SUM_W'({1'b0, {64{1'b1}}} >> (65 - ACC_BITS)));
  localparam logic signed [SUM_W-1:0] S_LO = ~S_HI;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = ~ACC_MAX;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // last index of a dimension: 0 acts as 1, anything past MAX_DIM as MAX_DIM
  function automatic logic [IDX_W-1:0] lim_of(input logic [3:0] d);
    logic [3:0] e;
    if (d == 4'd0) begin
      e = 4'd0;
    end else if (d > 4'(MAX_DIM)) begin
      e = 4'(MAX_DIM - 1);
    end else begin
      e = d - 4'd1;
    end
    return e[IDX_W-1:0];
  endfunction

  // sequencer
  logic             active;
  logic [IDX_W-1:0] ci, cj, ct;
  logic [IDX_W-1:0] m_lim, n_lim, k_lim;
  logic             adv, issue, idle, start;
  logic             t_end, j_end, i_end;

  // pipeline
  logic             s1_valid, s1_first, s1_last, s1_lastel, s1_cv;
  logic [IDX_W-1:0] s1_i, s1_j;
  logic             s2_valid, s2_first, s2_last, s2_lastel;
  logic [IDX_W-1:0] s2_i, s2_j;
  logic signed [PROD_W-1:0]   s2_prod;
  logic signed [ACC_BITS-1:0] s2_cinit;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] base;
  logic signed [SUM_W-1:0]    sum;
  logic signed [ACC_BITS-1:0] acc_sat;
  logic                       wb;

  // stores
  logic [OPERAND_BITS-1:0] a_rdata, b_rdata;
  logic [ACC_BITS-1:0]     c_rdata;
  logic [AW-1:0]           ld_addr, c_waddr;
  logic [ACC_BITS-1:0]     c_wdata;
  logic                    a_we, b_we, ld_c, c_we;
  logic [DEPTH-1:0]        c_vld;
  logic signed [63:0]      op_x, op_c, init_x, init_c;
  logic [OPERAND_BITS-1:0] op_val;

  assign m_lim = lim_of(rows_a);
  assign n_lim = lim_of(inner_dim);
  assign k_lim = lim_of(cols_b);

  assign adv     = !res_valid || res_ready;
  assign issue   = active && adv;
  assign idle    = !active && !s1_valid && !s2_valid;
  assign job_pop = job_valid && idle;
  assign start   = job_pop && (job.mode == MODE_COMPUTE);

  assign t_end = (ct == n_lim);
  assign j_end = (cj == k_lim);
  assign i_end = (ci == m_lim);

  // load path
  assign ld_addr = addr_of(IDX_W'(job.row_index), IDX_W'(job.col_index));
  assign a_we    = job_pop && (job.mode == MODE_LOAD_A);
  assign b_we    = job_pop && (job.mode == MODE_LOAD_B);
  assign ld_c    = job_pop && (job.mode == MODE_LOAD_C);

  always_comb begin
    op_x   = 64'(job.operand);
    init_x = 64'(job.acc_init);
    priority if (op_x > OP_HI) begin
      op_c = OP_HI;
    end else if (op_x < OP_LO) begin
      op_c = OP_LO;
    end else begin
      op_c = op_x;
    end
    priority if (init_x > INIT_HI) begin
      init_c = INIT_HI;
    end else if (init_x < INIT_LO) begin
      init_c = INIT_LO;
    end else begin
      init_c = init_x;
    end
  end

  assign op_val = op_c[OPERAND_BITS-1:0];

  // accumulate with saturation after every add
  assign base = s2_first ? s2_cinit : acc;
  assign sum  = SUM_W'(base) + SUM_W'(s2_prod);

  always_comb begin
    priority if (sum > S_HI) begin
      acc_sat = ACC_MAX;
    end else if (sum < S_LO) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = sum[ACC_BITS-1:0];
    end
  end

  assign wb = adv && s2_valid && s2_last;

  // loads only run while the pipeline is empty, so the two writers never collide
  assign c_we    = ld_c || wb;
  assign c_waddr = ld_c ? ld_addr : addr_of(s2_i, s2_j);
  assign c_wdata = ld_c ? init_c[ACC_BITS-1:0] : acc_sat;

  mma_ram #(.WIDTH(OPERAND_BITS), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (ld_addr),
    .wdata (op_val),
    .re    (issue),
    .raddr (addr_of(ci, ct)),
    .rdata (a_rdata)
  );

  mma_ram #(.WIDTH(OPERAND_BITS), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (ld_addr),
    .wdata (op_val),
    .re    (issue),
    .raddr (addr_of(ct, cj)),
    .rdata (b_rdata)
  );

  mma_ram #(.WIDTH(ACC_BITS), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (issue),
    .raddr (addr_of(ci, cj)),
    .rdata (c_rdata)
  );

  // C entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= '0;
    end else if (c_we) begin
      c_vld[c_waddr] <= 1'b1;
    end
  end

  // loop counters: t innermost, then j, then i
  always_ff @(posedge clk) begin
    if (start) begin
      ci <= '0;
      cj <= '0;
      ct <= '0;
    end else if (issue) begin
      if (t_end) begin
        ct <= '0;
        if (j_end) begin
          cj <= '0;
          ci <= ci + 1'b1;
        end else begin
          cj <= cj + 1'b1;
        end
      end else begin
        ct <= ct + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
      end else if (issue && t_end && j_end && i_end) begin
        active <= 1'b0;
      end
      if (adv) begin
        s1_valid  <= issue;
        s2_valid  <= s1_valid;
        res_valid <= s2_valid && s2_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first  <= (ct == '0);
      s1_last   <= t_end;
      s1_lastel <= t_end && j_end && i_end;
      s1_i      <= ci;
      s1_j      <= cj;
      s1_cv     <= c_vld[addr_of(ci, cj)];
      s2_first  <= s1_first;
      s2_last   <= s1_last;
      s2_lastel <= s1_lastel;
      s2_i      <= s1_i;
      s2_j      <= s1_j;
      s2_prod   <= $signed(a_rdata) * $signed(b_rdata);
      s2_cinit  <= s1_cv ? $signed(c_rdata) : '0;
      if (s2_valid) begin
        acc <= acc_sat;
      end
      if (wb) begin
        res.out_row   <= 3'(s2_i);
        res.out_col   <= 3'(s2_j);
        res.out_value <= 48'(acc_sat);
        res.out_last  <= s2_lastel;
      end
    end
  end

  `MMA_CHECK(a_pop_idle, job_pop, !active && !s1_valid && !s2_valid, "item taken while busy")
  `MMA_CHECK(a_lastel_end, s2_valid && s2_lastel, s2_last, "last element before its sum ends")
  `MMA_CHECK_NEXT(a_seq_stop, issue && t_end && j_end && i_end, !active, "sequencer ran past end")

endmodule
